/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands shared by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/nmk_pkg.sv */
// ----------------------------------------------------------------------------
// nmk_pkg
// Shared widths, codes and word types of the Newmark predictor/corrector.
// ----------------------------------------------------------------------------
package nmk_pkg;

	localparam int DOF_COUNT = 4096;
	localparam int DOF_AW    = (DOF_COUNT > 1) ? $clog2(DOF_COUNT) : 1;

	localparam int IDX_W     = 12;
	localparam int ACT_W     = 2;
	localparam int VAL_W     = 48;
	localparam int COEF_W    = 63;
	localparam int CFG_IDX_W = 3;

	// register stages of one multiply unit
	localparam int MUL_LAT   = 4;

	localparam logic [ACT_W-1:0] ACT_PREDICT = 2'd0;
	localparam logic [ACT_W-1:0] ACT_CORRECT = 2'd1;
	localparam logic [ACT_W-1:0] ACT_LOAD    = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_STEP_SIZE     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_COEF_DISP_ACC = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_COEF_VEL_ACC  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_COEF_ACC_GAIN = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_COEF_VEL_GAIN = 3'd4;

	localparam logic [COEF_W-1:0] STEP_SIZE_RST = 63'd4294967;

	typedef struct packed {
		logic [ACT_W-1:0]        action;
		logic [IDX_W-1:0]        dof_index;
		logic signed [VAL_W-1:0] value;
		logic signed [VAL_W-1:0] second_value;
	} item_t;

	typedef struct packed {
		logic [IDX_W-1:0]        out_index;
		logic [ACT_W-1:0]        out_action;
		logic signed [VAL_W-1:0] primary;
		logic signed [VAL_W-1:0] secondary;
		logic                    saturated;
	} result_t;

	// multiply unit result: signed value, its magnitude and sign, clip flag
	typedef struct packed {
		logic signed [VAL_W-1:0] val;
		logic [VAL_W-1:0]        mag;
		logic                    neg;
		logic                    ovf;
	} mul_res_t;

endpackage

/* rtl/nmk_ram.sv */
// ----------------------------------------------------------------------------
// nmk_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module nmk_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* rtl/nmk_mulq.sv */
// ----------------------------------------------------------------------------
// nmk_mulq
// Pipelined Q24.24 x Q31.32 multiply: magnitude times coefficient, shift
// by 32 with round half up, clip to the 48-bit signed range, apply sign.
// ----------------------------------------------------------------------------
module nmk_mulq import nmk_pkg::*; (
	input  logic               clk,
	input  logic [MUL_LAT-1:0] en,
	input  logic [VAL_W-1:0]   mag,
	input  logic               neg,
	input  logic [COEF_W-1:0]  coef,
	output mul_res_t           res
);

	localparam int ML_W    = VAL_W / 2;
	localparam int MH_W    = VAL_W - ML_W;
	localparam int CL_W    = 32;
	localparam int PP_W    = MH_W + CL_W;
	localparam int LO_W    = PP_W + ML_W + 1;
	localparam int HI_W    = PP_W + ML_W;
	localparam int MF_W    = HI_W + 1;

	logic [PP_W-1:0] pp0_s1, pp1_s1, pp2_s1, pp3_s1;
	logic            neg_s1, neg_s2, neg_s3;
	logic [LO_W-1:0] lo_s2;
	logic [HI_W-1:0] hi_s2;
	logic [MF_W-1:0] mf_s3;
	logic [MF_W-1:0] lim;
	logic            ovf;
	logic [VAL_W-1:0] magc;
	mul_res_t        res_s4;

	// partial products, 24 x 32 bits at most
	always_ff @(posedge clk) begin
		if (en[0]) begin
			pp0_s1 <= PP_W'(mag[ML_W-1:0]) * PP_W'(coef[CL_W-1:0]);
			pp1_s1 <= PP_W'(mag[VAL_W-1:ML_W]) * PP_W'(coef[CL_W-1:0]);
			pp2_s1 <= PP_W'(mag[ML_W-1:0]) * PP_W'(coef[COEF_W-1:CL_W]);
			pp3_s1 <= PP_W'(mag[VAL_W-1:ML_W]) * PP_W'(coef[COEF_W-1:CL_W]);
			neg_s1 <= neg;
		end
	end

	// low half carries the rounding constant (half an LSB of the result)
	always_ff @(posedge clk) begin
		if (en[1]) begin
			lo_s2  <= LO_W'(pp0_s1) + (LO_W'(pp1_s1) << ML_W) + (LO_W'(1) << (CL_W - 1));
			hi_s2  <= HI_W'(pp2_s1) + (HI_W'(pp3_s1) << ML_W);
			neg_s2 <= neg_s1;
		end
	end

	// rounded magnitude = hi + (lo >> 32)
	always_ff @(posedge clk) begin
		if (en[2]) begin
			mf_s3  <= MF_W'(hi_s2) + MF_W'(lo_s2[LO_W-1:CL_W]);
			neg_s3 <= neg_s2;
		end
	end

	always_comb begin
		lim  = (MF_W'(1) << (VAL_W - 1)) - MF_W'(!neg_s3);
		ovf  = mf_s3 > lim;
		magc = ovf ? lim[VAL_W-1:0] : mf_s3[VAL_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (en[3]) begin
			res_s4.val <= neg_s3 ? $signed(-magc) : $signed(magc);
			res_s4.mag <= magc;
			res_s4.neg <= neg_s3;
			res_s4.ovf <= ovf;
		end
	end

	assign res = res_s4;

endmodule

/* rtl/newmark_predictor_corrector.sv */
// ----------------------------------------------------------------------------
// newmark_predictor_corrector
// Newmark-beta predictor/corrector over a table of unknowns.
// Input words (item_valid/item_ready) carry an action, an unknown index and
// one or two Q24.24 values; one result word per input word leaves on
// result_valid/result_ready in input order. Coefficients are to be written on
// the cfg port only while no word is in flight; the block does not enforce it.
// A word passes the capture and operand stages, both multiply banks and the
// output register. One word per cycle is sustained while the receiver keeps
// up; a word whose unknown is still in flight waits at item_ready until the
// earlier one has written back. Two 4-stage multiply banks in series set the
// depth: the corrector multiplies twice.
// After reset the state tables are zeroed, one entry a cycle, over all 4096
// entries; item_ready stays low meanwhile, cfg writes are taken.
// A stalled receiver holds the output register; upstream stages keep filling
// bubbles, and ready falls once every stage is full. Nothing is dropped.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module newmark_predictor_corrector import nmk_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	output logic                 item_ready,
	input  item_t                item,
	output logic                 result_valid,
	input  logic                 result_ready,
	output result_t              result,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [COEF_W-1:0]    cfg_data
);

	localparam int NSTG  = 2 + 2 * MUL_LAT;
	localparam int MA0   = 3;
	localparam int MB0   = MA0 + MUL_LAT;
	localparam int SUM_W = VAL_W + 2;
	localparam int VA_W  = 2 * VAL_W;

	typedef struct packed {
		logic [ACT_W-1:0]        act;
		logic [IDX_W-1:0]        idx;
		logic                    ok;
		logic                    wr;
		logic signed [VAL_W-1:0] x0;
		logic signed [VAL_W-1:0] x1;
		logic                    flg;
	} side_t;

	function automatic logic sat_ovf(input logic [SUM_W-1:0] x);
		return (|x[SUM_W-1:VAL_W-1]) && !(&x[SUM_W-1:VAL_W-1]);
	endfunction

	function automatic logic [VAL_W-1:0] sat_val(input logic [SUM_W-1:0] x);
		logic [VAL_W-1:0] r;
		if (sat_ovf(x)) begin
			r = x[SUM_W-1] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
		end else begin
			r = x[VAL_W-1:0];
		end
		return r;
	endfunction

	// configuration
	logic [COEF_W-1:0] step_size_q, coef_disp_acc_q, coef_vel_acc_q;
	logic [COEF_W-1:0] coef_acc_gain_q, coef_vel_gain_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_size_q     <= STEP_SIZE_RST;
			coef_disp_acc_q <= '0;
			coef_vel_acc_q  <= '0;
			coef_acc_gain_q <= '0;
			coef_vel_gain_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_STEP_SIZE:     step_size_q     <= cfg_data;
				CFG_COEF_DISP_ACC: coef_disp_acc_q <= cfg_data;
				CFG_COEF_VEL_ACC:  coef_vel_acc_q  <= cfg_data;
				CFG_COEF_ACC_GAIN: coef_acc_gain_q <= cfg_data;
				CFG_COEF_VEL_GAIN: coef_vel_gain_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// clearing sweep
	logic              clr_busy_q;
	logic [DOF_AW-1:0] clr_addr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == DOF_AW'(DOF_COUNT - 1)) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	// pipeline control
	logic [NSTG:1]   vld_s;
	logic [NSTG+1:1] rdy;
	logic            res_vld_q;
	side_t           side_s [1:NSTG];
	logic            hazard;
	logic            accept;

	always_comb begin
		rdy[NSTG+1] = !res_vld_q || result_ready;
		for (int k = NSTG; k >= 1; k--) begin
			rdy[k] = !vld_s[k] || rdy[k+1];
		end
	end

	// same-unknown interlock against every word not yet written back
	always_comb begin
		hazard = 1'b0;
		for (int k = 1; k <= NSTG; k++) begin
			if (vld_s[k] && side_s[k].wr && side_s[k].idx == item.dof_index) begin
				hazard = 1'b1;
			end
		end
	end

	assign item_ready = !clr_busy_q && rdy[1] && !hazard;
	assign accept     = item_valid && item_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s     <= '0;
			res_vld_q <= 1'b0;
		end else begin
			if (rdy[1]) begin
				vld_s[1] <= accept;
			end
			for (int k = 2; k <= NSTG; k++) begin
				if (rdy[k]) begin
					vld_s[k] <= vld_s[k-1];
				end
			end
			if (rdy[NSTG+1]) begin
				res_vld_q <= vld_s[NSTG];
			end
		end
	end

	// stage 1: capture word, table reads issued on accept
	side_t side_in;

	always_comb begin
		side_in.act = item.action;
		side_in.idx = item.dof_index;
		side_in.ok  = 32'(item.dof_index) < DOF_COUNT;
		side_in.wr  = side_in.ok && (item.action inside {ACT_PREDICT, ACT_CORRECT, ACT_LOAD});
		side_in.x0  = item.value;
		side_in.x1  = item.second_value;
		side_in.flg = 1'b0;
	end

	logic [VA_W-1:0]   va_rdata, pr_rdata, va_wdata, pr_wdata;
	logic              va_we, pr_we, pipe_we;
	logic [DOF_AW-1:0] waddr;

	nmk_ram #(.WIDTH(VA_W), .DEPTH(DOF_COUNT)) u_va_ram (
		.clk   (clk),
		.we    (va_we),
		.waddr (waddr),
		.wdata (va_wdata),
		.re    (accept),
		.raddr (DOF_AW'(item.dof_index)),
		.rdata (va_rdata)
	);

	nmk_ram #(.WIDTH(VA_W), .DEPTH(DOF_COUNT)) u_pr_ram (
		.clk   (clk),
		.we    (pr_we),
		.waddr (waddr),
		.wdata (pr_wdata),
		.re    (accept),
		.raddr (DOF_AW'(item.dof_index)),
		.rdata (pr_rdata)
	);

	// stage 2: operand magnitudes for the first multiply bank
	logic signed [VAL_W-1:0] v_rd, a_rd, pd_rd, pv_rd;
	logic signed [VAL_W:0]   d_fwd, d_rev;
	side_t                   nx2;
	logic [VAL_W-1:0]        mag_d [3];
	logic                    neg_d [3];
	logic [VAL_W-1:0]        mag_s2 [3];
	logic                    neg_s2 [3];

	always_comb begin
		{v_rd, a_rd}   = va_rdata;
		{pd_rd, pv_rd} = pr_rdata;
		d_fwd = (VAL_W+1)'(side_s[1].x0) - (VAL_W+1)'(pd_rd);
		d_rev = (VAL_W+1)'(pd_rd) - (VAL_W+1)'(side_s[1].x0);
		nx2   = side_s[1];
		for (int l = 0; l < 3; l++) begin
			mag_d[l] = '0;
			neg_d[l] = 1'b0;
		end
		if (side_s[1].ok) begin
			case (side_s[1].act)
				ACT_PREDICT: begin
					nx2.x1   = v_rd;
					neg_d[0] = v_rd[VAL_W-1];
					mag_d[0] = neg_d[0] ? VAL_W'(-v_rd) : v_rd;
					neg_d[1] = a_rd[VAL_W-1];
					mag_d[1] = neg_d[1] ? VAL_W'(-a_rd) : a_rd;
					neg_d[2] = neg_d[1];
					mag_d[2] = mag_d[1];
				end
				ACT_CORRECT: begin
					// |s - pd| taken from whichever difference is non-negative
					nx2.x1   = pv_rd;
					neg_d[0] = d_fwd[VAL_W];
					mag_d[0] = neg_d[0] ? d_rev[VAL_W-1:0] : d_fwd[VAL_W-1:0];
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[2]) begin
			for (int l = 0; l < 3; l++) begin
				mag_s2[l] <= mag_d[l];
				neg_s2[l] <= neg_d[l];
			end
		end
	end

	// stages 3..6: first multiply bank
	logic [COEF_W-1:0] coef_a [3];
	mul_res_t          ra [3];
	mul_res_t          rb;

	always_comb begin
		coef_a[0] = (side_s[2].act == ACT_CORRECT) ? coef_acc_gain_q : step_size_q;
		coef_a[1] = coef_disp_acc_q;
		coef_a[2] = coef_vel_acc_q;
	end

	for (genvar l = 0; l < 3; l++) begin : g_bank_a
		nmk_mulq u_mulq (
			.clk  (clk),
			.en   (rdy[MA0+MUL_LAT-1:MA0]),
			.mag  (mag_s2[l]),
			.neg  (neg_s2[l]),
			.coef (coef_a[l]),
			.res  (ra[l])
		);
	end

	// stage 7: predictor sums, corrector acceleration; bank B starts here
	logic [SUM_W-1:0] sp, ss;
	side_t            nx7;

	always_comb begin
		sp  = SUM_W'($signed(side_s[MB0-1].x0)) + SUM_W'(ra[0].val) + SUM_W'(ra[1].val);
		ss  = SUM_W'($signed(side_s[MB0-1].x1)) + SUM_W'(ra[2].val);
		nx7 = side_s[MB0-1];
		if (!side_s[MB0-1].ok) begin
			nx7.x0  = '0;
			nx7.x1  = '0;
			nx7.flg = 1'b0;
		end else begin
			case (side_s[MB0-1].act)
				ACT_PREDICT: begin
					nx7.x0  = sat_val(sp);
					nx7.x1  = sat_val(ss);
					nx7.flg = ra[0].ovf | ra[1].ovf | ra[2].ovf | sat_ovf(sp) | sat_ovf(ss);
				end
				ACT_CORRECT: begin
					nx7.x0  = ra[0].val;
					nx7.flg = ra[0].ovf;
				end
				ACT_LOAD: nx7.flg = 1'b0;
				default: begin
					nx7.x0  = '0;
					nx7.x1  = '0;
					nx7.flg = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[1]) begin
			side_s[1] <= side_in;
		end
		if (rdy[2]) begin
			side_s[2] <= nx2;
		end
		for (int k = 3; k <= NSTG; k++) begin
			if (rdy[k]) begin
				side_s[k] <= (k == MB0) ? nx7 : side_s[k-1];
			end
		end
	end

	// stages 7..10: second multiply bank, a' * a3
	nmk_mulq u_mulq_b (
		.clk  (clk),
		.en   (rdy[MB0+MUL_LAT-1:MB0]),
		.mag  (ra[0].mag),
		.neg  (ra[0].neg),
		.coef (coef_vel_gain_q),
		.res  (rb)
	);

	// final: corrector velocity, write-back, output register
	logic [SUM_W-1:0] sv;
	side_t            fin;
	result_t          res_d, res_q;

	always_comb begin
		sv  = SUM_W'($signed(side_s[NSTG].x1)) + SUM_W'(rb.val);
		fin = side_s[NSTG];
		if (side_s[NSTG].ok && side_s[NSTG].act == ACT_CORRECT) begin
			fin.x1  = sat_val(sv);
			fin.flg = side_s[NSTG].flg | rb.ovf | sat_ovf(sv);
		end
		res_d.out_index  = fin.idx;
		res_d.out_action = fin.act;
		res_d.primary    = fin.x0;
		res_d.secondary  = fin.x1;
		res_d.saturated  = fin.flg;
	end

	assign pipe_we = vld_s[NSTG] && rdy[NSTG+1] && fin.wr;

	// table words: {velocity, acceleration} and {pred disp, pred vel}
	always_comb begin
		waddr    = clr_busy_q ? clr_addr_q : DOF_AW'(fin.idx);
		va_we    = clr_busy_q ||
		           (pipe_we && (fin.act == ACT_CORRECT || fin.act == ACT_LOAD));
		pr_we    = clr_busy_q || (pipe_we && fin.act == ACT_PREDICT);
		va_wdata = (fin.act == ACT_LOAD) ? {fin.x0, fin.x1} : {fin.x1, fin.x0};
		pr_wdata = {fin.x0, fin.x1};
		if (clr_busy_q) begin
			va_wdata = '0;
			pr_wdata = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[NSTG+1]) begin
			res_q <= res_d;
		end
	end

	assign result_valid = res_vld_q;
	assign result       = res_q;

	`ASSERT_IMPLIES(a_clear_empty, clk, arst_n, clr_busy_q, vld_s == '0 && !res_vld_q,
		"word in flight during table clear")
	`ASSERT_IMPLIES(a_no_stale_read, clk, arst_n, pipe_we && vld_s[1],
		side_s[NSTG].idx != side_s[1].idx, "read of an unknown with write-back pending")
	`ASSERT_NEXT(a_last_to_out, clk, arst_n, vld_s[NSTG] && rdy[NSTG+1], res_vld_q,
		"word lost leaving the last stage")

endmodule

/* tb/sv/newmark_predictor_corrector_test.sv */
// ----------------------------------------------------------------------------
// newmark_predictor_corrector_test
// Self-checking bench for the Newmark-beta predictor/corrector. A tracker
// object keeps its own copy of the per-unknown tables and coefficients and
// predicts every result word. Stimulus is a directed set followed by random
// load/predict/correct sequences under several coefficient sets and
// handshake idling mixes.
// ----------------------------------------------------------------------------
module newmark_predictor_corrector_test import nmk_pkg::*; ;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned CYCLE_LIMIT = 500000;
	localparam int PHASES = 6;
	localparam int PHASE_WORDS = 250;
	localparam int POOL = 8;

	localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

	localparam logic signed [VAL_W-1:0] VAL_MAX = 48'sh7FFF_FFFF_FFFF;
	localparam logic signed [VAL_W-1:0] VAL_MIN = 48'sh8000_0000_0000;
	localparam logic signed [VAL_W-1:0] ONE_Q = 48'sh0000_0100_0000;

	// dt = 1 ms, beta = 0.25, gamma = 0.5
	localparam logic [COEF_W-1:0] DT_1MS = 63'd4294967;
	localparam logic [COEF_W-1:0] A0_TYP = 63'd1074;
	localparam logic [COEF_W-1:0] A1_TYP = 63'd2147483;
	localparam logic [COEF_W-1:0] A2_TYP = 63'd17179869184000000;
	localparam logic [COEF_W-1:0] A3_TYP = 63'd2147483;
	localparam logic [COEF_W-1:0] COEF_MAX = '1;

	typedef enum int {NEED_LOAD, NEED_PREDICT, NEED_CORRECT} seq_step_t;

	class newmark_tracker;
		logic [COEF_W-1:0] dt, a0, a1, a2, a3;
		logic signed [VAL_W-1:0] vel[DOF_COUNT];
		logic signed [VAL_W-1:0] acc[DOF_COUNT];
		logic signed [VAL_W-1:0] pdisp[DOF_COUNT];
		logic signed [VAL_W-1:0] pvel[DOF_COUNT];
		result_t due[$];
		int mismatches;

		function new();
			dt = STEP_SIZE_RST;
			a0 = '0;
			a1 = '0;
			a2 = '0;
			a3 = '0;
			mismatches = 0;
			foreach (vel[i]) begin
				vel[i] = '0;
				acc[i] = '0;
				pdisp[i] = '0;
				pvel[i] = '0;
			end
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [COEF_W-1:0] data);
			case (idx)
				CFG_STEP_SIZE:     dt = data;
				CFG_COEF_DISP_ACC: a0 = data;
				CFG_COEF_VEL_ACC:  a1 = data;
				CFG_COEF_ACC_GAIN: a2 = data;
				CFG_COEF_VEL_GAIN: a3 = data;
				default: ;
			endcase
		endfunction

		// Q24.24 x Q31.32 -> Q24.24, round half away from zero, saturate
		function logic signed [VAL_W-1:0] mul_coef(logic signed [VAL_W:0] v,
				logic [COEF_W-1:0] c, inout bit clip);
			logic [VAL_W:0] m;
			logic [127:0] prod;
			logic [95:0] mag;
			logic [95:0] limit;
			logic [VAL_W-1:0] m48;
			m = v[VAL_W] ? (~v + 1'b1) : v;
			prod = m * c + 128'h8000_0000;
			mag = prod[127:32];
			limit = v[VAL_W] ? 96'h8000_0000_0000 : 96'h7FFF_FFFF_FFFF;
			if (mag > limit) begin
				clip = 1'b1;
				mag = limit;
			end
			m48 = mag[VAL_W-1:0];
			return v[VAL_W] ? (~m48 + 1'b1) : m48;
		endfunction

		function logic signed [VAL_W-1:0] clip48(logic signed [63:0] x, inout bit clip);
			if (x > 64'sh7FFF_FFFF_FFFF) begin
				clip = 1'b1;
				return VAL_MAX;
			end
			if (x < -64'sh8000_0000_0000) begin
				clip = 1'b1;
				return VAL_MIN;
			end
			return x[VAL_W-1:0];
		endfunction

		function void take_word(item_t w);
			result_t e;
			logic signed [VAL_W-1:0] val, t1, t2;
			logic signed [VAL_W:0] diff;
			logic signed [63:0] sum;
			bit clip;
			int idx;
			clip = 1'b0;
			idx = w.dof_index;
			val = $signed(w.value);
			e.out_index = w.dof_index;
			e.out_action = w.action;
			e.primary = '0;
			e.secondary = '0;
			if (idx < DOF_COUNT) begin
				case (w.action)
					ACT_PREDICT: begin
						t1 = mul_coef(vel[idx], dt, clip);
						t2 = mul_coef(acc[idx], a0, clip);
						sum = val + t1 + t2;
						e.primary = clip48(sum, clip);
						t1 = mul_coef(acc[idx], a1, clip);
						sum = vel[idx] + t1;
						e.secondary = clip48(sum, clip);
						pdisp[idx] = e.primary;
						pvel[idx] = e.secondary;
					end
					ACT_CORRECT: begin
						diff = val - pdisp[idx];
						e.primary = mul_coef(diff, a2, clip);
						t1 = mul_coef(e.primary, a3, clip);
						sum = pvel[idx] + t1;
						e.secondary = clip48(sum, clip);
						acc[idx] = e.primary;
						vel[idx] = e.secondary;
					end
					ACT_LOAD: begin
						e.primary = val;
						e.secondary = $signed(w.second_value);
						vel[idx] = e.primary;
						acc[idx] = e.secondary;
					end
					default: ;
				endcase
			end
			e.saturated = clip;
			due.push_back(e);
		endfunction

		function void check_word(result_t r);
			result_t e;
			mismatches++;
			if (due.size() == 0) begin
				if (mismatches <= 10)
					$display("%0t: unexpected result idx=%h act=%h p=%h s=%h sat=%b",
						$realtime, r.out_index, r.out_action, r.primary, r.secondary,
						r.saturated);
				return;
			end
			e = due.pop_front();
			if (r.out_index !== e.out_index || r.out_action !== e.out_action ||
					r.primary !== e.primary || r.secondary !== e.secondary ||
					r.saturated !== e.saturated) begin
				if (mismatches <= 10) begin
					$display("%0t: mismatch idx=%h/%h act=%h/%h (got/exp)",
						$realtime, r.out_index, e.out_index, r.out_action, e.out_action);
					$display("    primary=%h/%h secondary=%h/%h sat=%b/%b",
						r.primary, e.primary, r.secondary, e.secondary,
						r.saturated, e.saturated);
				end
				return;
			end
			mismatches--;
		endfunction

		function int waiting();
			return due.size();
		endfunction
	endclass

	logic clk;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_ready;
	item_t item = '0;
	logic result_valid;
	logic result_ready = 1'b0;
	result_t result;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [COEF_W-1:0] cfg_data = '0;

	newmark_tracker tracker = new();
	int send_pct = 0;
	int stall_pct = 0;
	int unsigned cycles = 0;
	logic [IDX_W-1:0] pool_idx[POOL];
	seq_step_t pool_step[POOL];

	newmark_predictor_corrector u_dut (
		.clk,
		.arst_n,
		.item_valid,
		.item_ready,
		.item,
		.result_valid,
		.result_ready,
		.result,
		.cfg_we,
		.cfg_index,
		.cfg_data
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	always @(posedge clk)
		result_ready <= ($urandom_range(99) >= stall_pct);

	always @(posedge clk)
		if (arst_n && result_valid && result_ready)
			tracker.check_word(result);

	function automatic logic signed [VAL_W-1:0] rand_full();
		logic [63:0] r;
		r = {$urandom, $urandom};
		return r[VAL_W-1:0];
	endfunction

	// about +/-32.0 in Q24.24
	function automatic logic signed [VAL_W-1:0] rand_small();
		logic [31:0] r;
		r = $urandom;
		return {{18{r[29]}}, r[29:0]};
	endfunction

	function automatic logic signed [VAL_W-1:0] rand_val();
		case ($urandom_range(7))
			0: return rand_full();
			1: begin
				case ($urandom_range(3))
					0: return VAL_MAX;
					1: return VAL_MIN;
					2: return '0;
					default: return '1;
				endcase
			end
			default: return rand_small();
		endcase
	endfunction

	function automatic logic [COEF_W-1:0] rand_coef();
		logic [63:0] r;
		r = {$urandom, $urandom} >> $urandom_range(62);
		return r[COEF_W-1:0];
	endfunction

	function automatic item_t word(logic [ACT_W-1:0] act, logic [IDX_W-1:0] idx,
			logic signed [VAL_W-1:0] v, logic signed [VAL_W-1:0] v2);
		item_t w;
		w.action = act;
		w.dof_index = idx;
		w.value = v;
		w.second_value = v2;
		return w;
	endfunction

	// mostly load -> predict -> correct chains on a small pool, some noise
	function automatic item_t next_word();
		item_t w;
		int slot;
		logic [IDX_W-1:0] idx;
		if ($urandom_range(99) < 15)
			return word(ACT_W'($urandom_range(3)), IDX_W'($urandom_range(4095)),
				rand_val(), rand_val());
		slot = $urandom_range(POOL - 1);
		idx = pool_idx[slot];
		w = word(ACT_LOAD, idx, rand_small(), rand_full());
		case (pool_step[slot])
			NEED_LOAD: begin
				w.value = rand_val();
				w.second_value = rand_small() >>> $urandom_range(20);
				pool_step[slot] = NEED_PREDICT;
			end
			NEED_PREDICT: begin
				w.action = ACT_PREDICT;
				pool_step[slot] = NEED_CORRECT;
			end
			default: begin
				w.action = ACT_CORRECT;
				w.value = tracker.pdisp[idx] + (rand_small() >>> $urandom_range(29));
				pool_step[slot] = ($urandom_range(9) == 0) ? NEED_LOAD : NEED_PREDICT;
			end
		endcase
		return w;
	endfunction

	task automatic send(item_t w);
		while ($urandom_range(99) < send_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		item <= w;
		do @(posedge clk); while (!item_ready);
		tracker.take_word(w);
	endtask

	task automatic drain();
		item_valid <= 1'b0;
		do @(posedge clk); while (tracker.waiting() != 0);
	endtask

	task automatic put_reg(logic [CFG_IDX_W-1:0] idx, logic [COEF_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		tracker.set_reg(idx, data);
	endtask

	task automatic set_coefs(logic [COEF_W-1:0] dt, logic [COEF_W-1:0] a0,
			logic [COEF_W-1:0] a1, logic [COEF_W-1:0] a2, logic [COEF_W-1:0] a3);
		put_reg(CFG_STEP_SIZE, dt);
		put_reg(CFG_COEF_DISP_ACC, a0);
		put_reg(CFG_COEF_VEL_ACC, a1);
		put_reg(CFG_COEF_ACC_GAIN, a2);
		put_reg(CFG_COEF_VEL_GAIN, a3);
		// out-of-map index must be ignored
		put_reg(CFG_UNUSED, rand_coef());
		cfg_we <= 1'b0;
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// table clear runs after reset; cfg writes are taken meanwhile
		set_coefs(DT_1MS, A0_TYP, A1_TYP, A2_TYP, A3_TYP);

		send(word(ACT_LOAD, 12'd0, VAL_MAX, VAL_MIN));
		send(word(ACT_PREDICT, 12'd0, VAL_MAX, '0));
		send(word(ACT_CORRECT, 12'd0, VAL_MIN, '1));
		send(word(ACT_LOAD, 12'd4095, VAL_MIN, VAL_MAX));
		send(word(ACT_PREDICT, 12'd4095, VAL_MIN, VAL_MAX));
		send(word(ACT_CORRECT, 12'd4095, VAL_MAX, VAL_MIN));
		// never-loaded unknown: zero state
		send(word(ACT_PREDICT, 12'd7, ONE_Q, '0));
		send(word(ACT_CORRECT, 12'd7, ONE_Q + 48'sd4096, '0));
		send(word(ACT_UNUSED, 12'd9, rand_full(), rand_full()));
		send(word(ACT_UNUSED, 12'd4095, VAL_MAX, VAL_MIN));
		send(word(ACT_LOAD, 12'd100, ONE_Q, -(ONE_Q <<< 1)));
		send(word(ACT_PREDICT, 12'd100, '0, '0));
		send(word(ACT_CORRECT, 12'd100, -48'sd5000, '0));
		send(word(ACT_PREDICT, 12'd100, ONE_Q, '0));
		send(word(ACT_LOAD, 12'd0, '0, '0));
		send(word(ACT_PREDICT, 12'd0, '1, '0));
		send(word(ACT_CORRECT, 12'd0, '0, '0));
		send(word(ACT_LOAD, 12'hAAA, 48'shAAAA_AAAA_AAAA, 48'sh5555_5555_5555));
		send(word(ACT_PREDICT, 12'hAAA, 48'sh5555_5555_5555, 48'shAAAA_AAAA_AAAA));
		send(word(ACT_CORRECT, 12'hAAA, 48'shAAAA_AAAA_AAAA, 48'sh5555_5555_5555));
		send(word(ACT_UNUSED, 12'h555, 48'sh5555_5555_5555, 48'shAAAA_AAAA_AAAA));

		for (int ph = 0; ph < PHASES; ph++) begin
			drain();
			repeat (12) @(posedge clk);
			case (ph)
				0: set_coefs(DT_1MS, A0_TYP, A1_TYP, A2_TYP, A3_TYP);
				1: set_coefs(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX);
				3: set_coefs('0, '0, '0, '0, '0);
				5: set_coefs(DT_1MS, A0_TYP, A1_TYP, A2_TYP, A3_TYP);
				default: set_coefs(rand_coef(), rand_coef(), rand_coef(), rand_coef(),
					rand_coef());
			endcase
			case (ph)
				1: begin send_pct = 79; stall_pct = 0; end
				2: begin send_pct = 0; stall_pct = 79; end
				3, 5: begin send_pct = 29; stall_pct = 29; end
				default: begin send_pct = 0; stall_pct = 0; end
			endcase
			foreach (pool_idx[i]) begin
				pool_idx[i] = IDX_W'($urandom_range(4095));
				pool_step[i] = ($urandom_range(3) == 0) ? NEED_PREDICT : NEED_LOAD;
			end
			for (int n = 0; n < PHASE_WORDS; n++) begin
				// hold off until the pipe is empty once
				if (ph == 2 && n == PHASE_WORDS / 2)
					drain();
				send(next_word());
			end
		end

		drain();
		repeat (20) @(posedge clk);
		if (tracker.mismatches == 0 && tracker.waiting() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
